// ----- hw/rtl/clsr_pkg.sv -----
package clsr_pkg;

  // Display geometry
  localparam int LINE_CHARS = 16;
  localparam int POS_W      = $clog2(LINE_CHARS + 1);
  localparam int ADDR_W     = 5;
  localparam int STORE_DEPTH   = 32;
  localparam int LINE_TWO_BASE = 16;

  localparam logic [POS_W-1:0] LINE_W    = POS_W'(LINE_CHARS);
  localparam logic [POS_W-1:0] LINE_LAST = POS_W'(LINE_CHARS - 1);

  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] SEL_LINE_ONE = 8'h80;
  localparam logic [7:0] SEL_LINE_TWO = 8'hC0;

  // Item commands
  typedef enum logic [2:0] {
    CMD_INIT       = 3'd0,
    CMD_DEINIT     = 3'd1,
    CMD_START_LINE = 3'd2,
    CMD_PUT_CHAR   = 3'd3,
    CMD_UPDATE     = 3'd4
  } cmd_t;

  // Refresh progress kept between update items
  typedef enum logic [1:0] {
    PH_SEL_ONE  = 2'd0,
    PH_LINE_ONE = 2'd1,
    PH_SEL_TWO  = 2'd2,
    PH_LINE_TWO = 2'd3
  } phase_t;

  // Where the byte of a step comes from
  typedef enum logic [1:0] {
    SRC_CONST    = 2'd0,
    SRC_LINE_ONE = 2'd1,
    SRC_SPACE    = 2'd2,
    SRC_LINE_TWO = 2'd3
  } src_t;

  typedef enum logic [2:0] {
    WAIT_NONE   = 3'd0,
    WAIT_15MS   = 3'd1,
    WAIT_5MS    = 3'd2,
    WAIT_100US  = 3'd3,
    WAIT_1640US = 3'd4
  } wait_t;

  // Sequencing of a step
  typedef enum logic [2:0] {
    NX_NEXT     = 3'd0,
    NX_LOOP     = 3'd1,
    NX_SMOOTH   = 3'd2,
    NX_END      = 3'd3,
    NX_LINE_TWO = 3'd4
  } nxt_t;

  typedef logic [3:0] pc_t;

  localparam pc_t PC_INIT      = 4'd0;
  localparam pc_t PC_SEL_ONE   = 4'd8;
  localparam pc_t PC_LINE_ONE  = 4'd9;
  localparam pc_t PC_SEL_TWO   = 4'd10;
  localparam pc_t PC_BLANK     = 4'd11;
  localparam pc_t PC_RESEL_TWO = 4'd12;
  localparam pc_t PC_LINE_TWO  = 4'd13;

  typedef struct packed {
    src_t       src;
    logic       rs;
    logic       high_only;
    logic [7:0] data;
    wait_t      wt;
    nxt_t       nxt;
    pc_t        target;
    logic       clr_pos;
  } uop_t;

  // Accepted item as seen by sequencer and datapath
  typedef struct packed {
    logic       take;
    logic [2:0] command;
    logic [7:0] char_code;
    logic       smooth;
  } req_t;

  // One bus step handed from sequencer to datapath
  typedef struct packed {
    logic              fire;
    logic              is_write;
    logic              rs;
    src_t              src;
    logic [7:0]        data;
    logic              high_only;
    wait_t             wt;
    logic              done;
    logic              last;
    logic [ADDR_W-1:0] rd_addr;
  } step_t;

  function automatic logic [13:0] wait_us(input wait_t w);
    logic [13:0] v;
    case (w)
      WAIT_15MS:   v = 14'd15000;
      WAIT_5MS:    v = 14'd5000;
      WAIT_100US:  v = 14'd100;
      WAIT_1640US: v = 14'd1640;
      default:     v = 14'd0;
    endcase
    return v;
  endfunction

  function automatic uop_t mk(input src_t src, input logic rs, input logic ho,
                              input logic [7:0] data, input wait_t wt,
                              input nxt_t nxt, input pc_t target, input logic clr);
    uop_t u;
    u.src       = src;
    u.rs        = rs;
    u.high_only = ho;
    u.data      = data;
    u.wt        = wt;
    u.nxt       = nxt;
    u.target    = target;
    u.clr_pos   = clr;
    return u;
  endfunction

  // Microcode: power-up sequence, then the screen refresh routine
  function automatic uop_t ucode(input pc_t pc);
    uop_t u;
    case (pc)
      4'd0:  u = mk(SRC_CONST, 1'b0, 1'b1, 8'h30, WAIT_15MS, NX_NEXT, PC_INIT, 1'b0);
      4'd1:  u = mk(SRC_CONST, 1'b0, 1'b1, 8'h30, WAIT_5MS, NX_NEXT, PC_INIT, 1'b0);
      4'd2:  u = mk(SRC_CONST, 1'b0, 1'b1, 8'h30, WAIT_100US, NX_NEXT, PC_INIT, 1'b0);
      4'd3:  u = mk(SRC_CONST, 1'b0, 1'b1, 8'h20, WAIT_NONE, NX_NEXT, PC_INIT, 1'b0);
      4'd4:  u = mk(SRC_CONST, 1'b0, 1'b0, 8'h28, WAIT_NONE, NX_NEXT, PC_INIT, 1'b0);
      4'd5:  u = mk(SRC_CONST, 1'b0, 1'b0, 8'h0C, WAIT_NONE, NX_NEXT, PC_INIT, 1'b0);
      4'd6:  u = mk(SRC_CONST, 1'b0, 1'b0, 8'h01, WAIT_NONE, NX_NEXT, PC_INIT, 1'b0);
      4'd7:  u = mk(SRC_CONST, 1'b0, 1'b0, 8'h06, WAIT_1640US, NX_END, PC_INIT, 1'b0);
      PC_SEL_ONE:
        u = mk(SRC_CONST, 1'b0, 1'b0, SEL_LINE_ONE, WAIT_NONE, NX_NEXT, PC_INIT, 1'b1);
      PC_LINE_ONE:
        u = mk(SRC_LINE_ONE, 1'b1, 1'b0, 8'h00, WAIT_NONE, NX_LOOP, PC_INIT, 1'b0);
      PC_SEL_TWO:
        u = mk(SRC_CONST, 1'b0, 1'b0, SEL_LINE_TWO, WAIT_NONE, NX_SMOOTH, PC_LINE_TWO,
               1'b1);
      PC_BLANK:
        u = mk(SRC_SPACE, 1'b1, 1'b0, 8'h00, WAIT_NONE, NX_LOOP, PC_INIT, 1'b0);
      PC_RESEL_TWO:
        u = mk(SRC_CONST, 1'b0, 1'b0, SEL_LINE_TWO, WAIT_NONE, NX_NEXT, PC_INIT, 1'b0);
      PC_LINE_TWO:
        u = mk(SRC_LINE_TWO, 1'b1, 1'b0, 8'h00, WAIT_NONE, NX_LINE_TWO, PC_INIT, 1'b0);
      default:
        u = mk(SRC_CONST, 1'b0, 1'b0, 8'h00, WAIT_NONE, NX_END, PC_INIT, 1'b0);
    endcase
    return u;
  endfunction

endpackage

// ----- hw/rtl/clsr_in_if.sv -----
interface clsr_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] char_code;
  logic       smooth;

  modport source (output valid, output command, output char_code, output smooth,
                  input ready);
  modport sink (input valid, input command, input char_code, input smooth,
                output ready);
endinterface

// ----- hw/rtl/clsr_out_if.sv -----
interface clsr_out_if;
  logic        valid;
  logic        ready;
  logic        is_write;
  logic        reg_select;
  logic [7:0]  data_byte;
  logic        high_only;
  logic [13:0] wait_before_us;
  logic        done_res;
  logic        last;

  modport source (output valid, output is_write, output reg_select, output data_byte,
                  output high_only, output wait_before_us, output done_res,
                  output last, input ready);
  modport sink (input valid, input is_write, input reg_select, input data_byte,
                input high_only, input wait_before_us, input done_res, input last,
                output ready);
endinterface

// ----- hw/rtl/char_lcd_scroll_refresh.sv -----
// Result items come from the sequencer after acceptance, through the output register.
// Throughput: one bus write per cycle from the microcode sequencer unless the output
//   stalls; init 8 items, update up to 36; next item is taken after the final result.
// Silent items (deinit, start line, put char) give no result and leave the block idle.
// Reset (rst, synchronous, active high) clears the store to zero, the initialized flag,
//   fill and refresh positions, and selects line one as the next refresh phase.
module char_lcd_scroll_refresh (
  input  logic       clk,
  input  logic       rst,
  clsr_in_if.sink    request,
  clsr_out_if.source result
);

  clsr_pkg::req_t  req;
  clsr_pkg::step_t step;
  logic            busy;
  logic            slot_free;

  // Items are taken only while the sequencer is idle
  assign request.ready = !busy;

  always_comb begin
    req.take      = request.valid && !busy;
    req.command   = request.command;
    req.char_code = request.char_code;
    req.smooth    = request.smooth;
  end

  clsr_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .slot_free (slot_free),
    .busy      (busy),
    .step      (step)
  );

  clsr_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .step      (step),
    .slot_free (slot_free),
    .result    (result)
  );

endmodule

// ----- hw/rtl/clsr_seq.sv -----
module clsr_seq (
  input  logic            clk,
  input  logic            rst,
  input  clsr_pkg::req_t  req,
  input  logic            slot_free,
  output logic            busy,
  output clsr_pkg::step_t step
);

  clsr_pkg::pc_t              pc;
  logic [clsr_pkg::POS_W-1:0] cnt;
  logic                       smooth_q;
  clsr_pkg::phase_t           refresh_phase;
  logic [clsr_pkg::POS_W-1:0] refresh_position;

  clsr_pkg::uop_t uop;
  clsr_pkg::pc_t  entry_pc;
  logic           fire;
  logic           is_l2;
  logic           pos_lt_w;
  logic           l2_end;
  logic           l2_done;
  logic           status;
  logic           start_init;
  logic           start_upd;

  // Control word of the current step
  assign uop  = clsr_pkg::ucode(pc);
  assign fire = busy && slot_free;

  // Line-two step: one char in smooth mode, the rest otherwise
  assign is_l2    = (uop.nxt == clsr_pkg::NX_LINE_TWO);
  assign pos_lt_w = (refresh_position < clsr_pkg::LINE_W);
  assign l2_end   = smooth_q || !pos_lt_w || (refresh_position == clsr_pkg::LINE_LAST);
  assign l2_done  = !(smooth_q && pos_lt_w);
  assign status   = is_l2 && !pos_lt_w;

  assign start_init = req.take && (req.command == clsr_pkg::CMD_INIT);
  assign start_upd  = req.take && (req.command == clsr_pkg::CMD_UPDATE);

  // Update entry point from the saved refresh phase
  always_comb begin
    case (refresh_phase)
      clsr_pkg::PH_SEL_ONE:  entry_pc = clsr_pkg::PC_SEL_ONE;
      clsr_pkg::PH_LINE_ONE: entry_pc = clsr_pkg::PC_LINE_ONE;
      clsr_pkg::PH_SEL_TWO:  entry_pc = clsr_pkg::PC_SEL_TWO;
      default:               entry_pc = clsr_pkg::PC_LINE_TWO;
    endcase
  end

  // Step handed to the datapath
  always_comb begin
    step.fire      = fire;
    step.is_write  = !status;
    step.rs        = status ? 1'b0 : uop.rs;
    step.src       = status ? clsr_pkg::SRC_CONST : uop.src;
    step.data      = status ? 8'h00 : uop.data;
    step.high_only = uop.high_only;
    step.wt        = uop.wt;
    step.last      = (uop.nxt == clsr_pkg::NX_END) || (is_l2 && l2_end);
    step.done      = is_l2 && l2_end && l2_done;
    if (uop.src == clsr_pkg::SRC_LINE_TWO) begin
      step.rd_addr = refresh_position + clsr_pkg::ADDR_W'(clsr_pkg::LINE_TWO_BASE);
    end else begin
      step.rd_addr = cnt;
    end
  end

  // Step counter, loop counter and refresh progress
  always_ff @(posedge clk) begin
    if (rst) begin
      busy             <= 1'b0;
      pc               <= clsr_pkg::PC_INIT;
      cnt              <= '0;
      smooth_q         <= 1'b0;
      refresh_phase    <= clsr_pkg::PH_SEL_ONE;
      refresh_position <= '0;
    end else if (start_init || start_upd) begin
      busy     <= 1'b1;
      smooth_q <= req.smooth;
      cnt      <= '0;
      pc       <= start_init ? clsr_pkg::PC_INIT : entry_pc;
    end else if (fire) begin
      if (uop.clr_pos) begin
        refresh_position <= '0;
      end
      case (uop.nxt)
        clsr_pkg::NX_NEXT: begin
          pc <= pc + 4'd1;
        end
        clsr_pkg::NX_LOOP: begin
          if (cnt == clsr_pkg::LINE_LAST) begin
            cnt <= '0;
            pc  <= pc + 4'd1;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        clsr_pkg::NX_SMOOTH: begin
          pc <= smooth_q ? pc + 4'd1 : uop.target;
        end
        clsr_pkg::NX_LINE_TWO: begin
          if (pos_lt_w) begin
            refresh_position <= refresh_position + 1'b1;
          end
          if (l2_end) begin
            busy          <= 1'b0;
            refresh_phase <= l2_done ? clsr_pkg::PH_SEL_ONE : clsr_pkg::PH_LINE_TWO;
          end
        end
        default: begin
          busy <= 1'b0;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_phase_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (refresh_phase == clsr_pkg::PH_SEL_ONE ||
               refresh_phase == clsr_pkg::PH_LINE_TWO))
    else $error("refresh phase left mid-line between items");
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    refresh_position <= clsr_pkg::LINE_W)
    else $error("refresh position past line width");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    step.fire && step.last |=> !busy)
    else $error("sequencer still busy after final step");
  a_status_done: assert property (@(posedge clk) disable iff (rst)
    step.fire && !step.is_write |-> step.done && step.last)
    else $error("status result without done and last");
`endif

endmodule

// ----- hw/rtl/clsr_dpath.sv -----
module clsr_dpath (
  input  logic            clk,
  input  logic            rst,
  input  clsr_pkg::req_t  req,
  input  clsr_pkg::step_t step,
  output logic            slot_free,
  clsr_out_if.source      result
);

  logic [7:0]                 store [clsr_pkg::STORE_DEPTH];
  logic                       initialized;
  logic [clsr_pkg::POS_W-1:0] fill_position;
  logic [7:0]                 byte_sel;
  logic [clsr_pkg::ADDR_W-1:0] put_addr;

  assign slot_free = !result.valid || result.ready;
  assign put_addr  = clsr_pkg::ADDR_W'(clsr_pkg::LINE_TWO_BASE) +
                     clsr_pkg::ADDR_W'(fill_position);

  // Byte of the current step
  always_comb begin
    case (step.src)
      clsr_pkg::SRC_LINE_ONE: byte_sel = store[step.rd_addr];
      clsr_pkg::SRC_LINE_TWO: byte_sel = store[step.rd_addr];
      clsr_pkg::SRC_SPACE:    byte_sel = clsr_pkg::SPACE_CHAR;
      default:                byte_sel = step.data;
    endcase
  end

  // Character store and fill state, updated at item acceptance
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < clsr_pkg::STORE_DEPTH; i++) begin
        store[clsr_pkg::ADDR_W'(i)] <= 8'h00;
      end
      initialized   <= 1'b0;
      fill_position <= '0;
    end else if (req.take) begin
      case (req.command)
        clsr_pkg::CMD_INIT: begin
          for (int i = 0; i < clsr_pkg::STORE_DEPTH; i++) begin
            store[clsr_pkg::ADDR_W'(i)] <= clsr_pkg::SPACE_CHAR;
          end
          fill_position <= '0;
          initialized   <= 1'b1;
        end
        clsr_pkg::CMD_DEINIT: begin
          initialized <= 1'b0;
        end
        clsr_pkg::CMD_START_LINE: begin
          if (initialized) begin
            for (int i = 0; i < clsr_pkg::LINE_TWO_BASE; i++) begin
              store[clsr_pkg::ADDR_W'(i)] <=
                store[clsr_pkg::ADDR_W'(i + clsr_pkg::LINE_TWO_BASE)];
              store[clsr_pkg::ADDR_W'(i + clsr_pkg::LINE_TWO_BASE)] <=
                clsr_pkg::SPACE_CHAR;
            end
            fill_position <= '0;
          end
        end
        clsr_pkg::CMD_PUT_CHAR: begin
          if (initialized && (fill_position < clsr_pkg::LINE_W)) begin
            store[put_addr] <= req.char_code;
            fill_position   <= fill_position + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (step.fire) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.fire) begin
      result.is_write       <= step.is_write;
      result.reg_select     <= step.rs;
      result.data_byte      <= step.is_write ? byte_sel : 8'h00;
      result.high_only      <= step.high_only;
      result.wait_before_us <= clsr_pkg::wait_us(step.wt);
      result.done_res       <= step.done;
      result.last           <= step.last;
    end
  end

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill_position <= clsr_pkg::LINE_W)
    else $error("fill position past line width");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    step.fire |-> !result.valid || result.ready)
    else $error("result register overwritten while held");
`endif

endmodule
